// ----- sv/bla_pkg.sv -----
// Shared types and constants for the battery low alarm unit.
// Holds payload structs, alarm mode codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package bla_pkg;

   localparam int MV_W       = 15;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int TRANS_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [MV_W-1:0]       FLOOR_MV_RST    = 15'd6000;
   localparam logic [MV_W-1:0]       WARN_MV_RST     = 15'd12200;
   localparam logic [MV_W-1:0]       CRIT_MV_RST     = 15'd11300;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = 16'd500;
   localparam logic [TRANS_W-1:0]    TRANSITIONS_RST = 4'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLOOR_MV           = 3'd0,
      CSR_WARN_MV            = 3'd1,
      CSR_CRIT_MV            = 3'd2,
      CSR_TOGGLE_INTERVAL_MS = 3'd3,
      CSR_WARN_TRANSITIONS   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_WARN = 2'd1,
      MODE_CONT = 2'd2
   } alarm_mode_type;

   typedef struct packed {
      logic [MV_W-1:0]   battery_mv;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       buzzer_on;
      logic [1:0] alarm_mode;
      logic       sample_valid;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/battery_low_alarm_unit.sv -----
// Top level of the battery low alarm unit: input register, alarm update, result register.
// Depends on bla_pkg for payload structs, mode codes and register reset values.
// A sample passes the input register and then the result register; throughput: one sample
// per cycle unless rsp_stall holds back a waiting result. The alarm state updates as a sample
// leaves the input register. Synchronous active-high reset restores register defaults, clears
// alarm state and empties both stages.
`default_nettype none

module battery_low_alarm_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  bla_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output bla_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_wr_en,
   input  wire  [bla_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [bla_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import bla_pkg::*;

   logic [MV_W-1:0]       floor_mv_ff;
   logic [MV_W-1:0]       warn_mv_ff;
   logic [MV_W-1:0]       crit_mv_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [TRANS_W-1:0]    transitions_ff;

   logic       s1_valid_ff;
   req_type    s1_data_ff;
   logic       out_valid_ff;
   rsp_type    out_data_ff;
   rsp_type    out_data_in;
   logic       advance;

   logic                  hist_valid_ff, hist_valid_in;
   logic [MV_W-1:0]       prev_mv_ff, prev_mv_in;
   alarm_mode_type        mode_ff, mode_in;
   logic                  buzzer_ff, buzzer_in;
   logic [TIME_W-1:0]     last_toggle_ff, last_toggle_in;
   logic [TRANS_W-1:0]    toggles_left_ff, toggles_left_in;

   logic                  crossed;
   logic [TIME_W-1:0]     elapsed;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_mv_ff    <= FLOOR_MV_RST;
         warn_mv_ff     <= WARN_MV_RST;
         crit_mv_ff     <= CRIT_MV_RST;
         interval_ff    <= INTERVAL_RST;
         transitions_ff <= TRANSITIONS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FLOOR_MV:           floor_mv_ff    <= csr_wdata[MV_W-1:0];
            CSR_WARN_MV:            warn_mv_ff     <= csr_wdata[MV_W-1:0];
            CSR_CRIT_MV:            crit_mv_ff     <= csr_wdata[MV_W-1:0];
            CSR_TOGGLE_INTERVAL_MS: interval_ff    <= csr_wdata[INTERVAL_W-1:0];
            CSR_WARN_TRANSITIONS:   transitions_ff <= csr_wdata[TRANS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      hist_valid_in   = hist_valid_ff;
      prev_mv_in      = prev_mv_ff;
      mode_in         = mode_ff;
      buzzer_in       = buzzer_ff;
      last_toggle_in  = last_toggle_ff;
      toggles_left_in = toggles_left_ff;
      crossed         = (prev_mv_ff >= warn_mv_ff) && (s1_data_ff.battery_mv < warn_mv_ff);
      elapsed         = '0;
      if (s1_data_ff.battery_mv < floor_mv_ff) begin
         mode_in         = MODE_IDLE;
         toggles_left_in = '0;
         buzzer_in       = 1'b0;
         hist_valid_in   = 1'b0;
         prev_mv_in      = s1_data_ff.battery_mv;
      end else if (!hist_valid_ff) begin
         hist_valid_in = 1'b1;
         prev_mv_in    = s1_data_ff.battery_mv;
      end else begin
         if (s1_data_ff.battery_mv < crit_mv_ff) begin
            if (mode_ff != MODE_CONT) begin
               mode_in         = MODE_CONT;
               toggles_left_in = '0;
               buzzer_in       = 1'b1;
            end
         end else begin
            if (mode_ff == MODE_CONT) begin
               mode_in         = MODE_IDLE;
               toggles_left_in = '0;
               buzzer_in       = 1'b0;
            end
            if (crossed && mode_in == MODE_IDLE) begin
               mode_in         = MODE_WARN;
               toggles_left_in = transitions_ff;
               last_toggle_in  = s1_data_ff.now_ms;
               buzzer_in       = 1'b1;
            end
         end
         elapsed = s1_data_ff.now_ms - last_toggle_in;
         if (mode_in == MODE_WARN &&
             elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, interval_ff}) begin
            last_toggle_in = s1_data_ff.now_ms;
            buzzer_in      = !buzzer_in;
            if (toggles_left_in <= TRANS_W'(1)) begin
               mode_in         = MODE_IDLE;
               toggles_left_in = '0;
               buzzer_in       = 1'b0;
            end else begin
               toggles_left_in = toggles_left_in - TRANS_W'(1);
            end
         end
         prev_mv_in = s1_data_ff.battery_mv;
      end
      out_data_in.buzzer_on    = buzzer_in;
      out_data_in.alarm_mode   = mode_in;
      out_data_in.sample_valid = hist_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         hist_valid_ff   <= 1'b0;
         prev_mv_ff      <= '0;
         mode_ff         <= MODE_IDLE;
         buzzer_ff       <= 1'b0;
         last_toggle_ff  <= '0;
         toggles_left_ff <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
            s1_valid_ff  <= req_valid;
            if (s1_valid_ff) begin
               hist_valid_ff   <= hist_valid_in;
               prev_mv_ff      <= prev_mv_in;
               mode_ff         <= mode_in;
               buzzer_ff       <= buzzer_in;
               last_toggle_ff  <= last_toggle_in;
               toggles_left_ff <= toggles_left_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (req_valid) begin
            s1_data_ff <= req_data;
         end
         if (s1_valid_ff) begin
            out_data_ff <= out_data_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> !buzzer_ff)
      else $error("buzzer sounding while idle");
   a_cont_loud: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_CONT |-> buzzer_ff)
      else $error("buzzer silent during continuous alarm");
   a_no_hist_idle: assert property (@(posedge clock) disable iff (reset)
      !hist_valid_ff |-> mode_ff == MODE_IDLE)
      else $error("alarm active without sample history");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while both stages are blocked");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result appeared without a sample in the input stage");
`endif

endmodule

`default_nettype wire
